// ----- design/led_hold_and_beep_pattern_sequencer_macros.svh -----
// assertion macros for the led hold and beep pattern sequencer
// used by the top level only; no dependencies
`ifndef LED_HOLD_AND_BEEP_PATTERN_SEQUENCER_MACROS_SVH
`define LED_HOLD_AND_BEEP_PATTERN_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk_i, off during reset
`define LHB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lhb assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define LHB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lhb assertion failed");

`else

`define LHB_ASSERT_IMP(lbl, ante, cons)
`define LHB_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- design/lhb_pkg.sv -----
// types, constants and helpers for the led hold and beep pattern sequencer
// no dependencies; imported by every module of the block

package lhb_pkg;

  // timer and register widths
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned COUNT_W = 8;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [LEVEL_W-1:0] LIT_THRESHOLD = 8'd127;

  // register reset values
  localparam logic [CFG_W-1:0] RST_LONG_HOLD  = 16'd1500;
  localparam logic [CFG_W-1:0] RST_SHORT_HOLD = 16'd250;
  localparam logic [CFG_W-1:0] RST_SHORT_BEEP = 16'd60;
  localparam logic [CFG_W-1:0] RST_SHORT_GAP  = 16'd80;
  localparam logic [CFG_W-1:0] RST_LONG_BEEP  = 16'd400;

  // beep counts of the cues
  localparam logic [COUNT_W-1:0] DOUBLE_BEEPS = 8'd2;
  localparam logic [COUNT_W-1:0] SINGLE_BEEP  = 8'd1;

  // lit bit positions
  localparam logic [2:0] LIT_NONE  = 3'b000;
  localparam logic [2:0] LIT_RED   = 3'b001;
  localparam logic [2:0] LIT_GREEN = 3'b010;
  localparam logic [2:0] LIT_BLUE  = 3'b100;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_COLOUR  = 3'd1,
    REQ_LED_OFF = 3'd2,
    REQ_BEEPS   = 3'd3,
    REQ_SUCCESS = 3'd4,
    REQ_ERROR   = 3'd5,
    REQ_SCAN    = 3'd6,
    REQ_WRITE   = 3'd7
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_HIGH = 3'd0,
    CFG_LONG_HOLD   = 3'd1,
    CFG_SHORT_HOLD  = 3'd2,
    CFG_SHORT_BEEP  = 3'd3,
    CFG_SHORT_GAP   = 3'd4,
    CFG_LONG_BEEP   = 3'd5
  } cfg_idx_e;

  // input beat
  typedef struct packed {
    logic [2:0]          req_type;
    logic [LEVEL_W-1:0]  red_level;
    logic [LEVEL_W-1:0]  green_level;
    logic [LEVEL_W-1:0]  blue_level;
    logic [COUNT_W-1:0]  beep_count;
    logic [15:0]         beep_on_ticks;
    logic [15:0]         beep_gap_ticks;
  } lhb_in_t;

  // result beat
  typedef struct packed {
    logic red_pin;
    logic green_pin;
    logic blue_pin;
    logic buzzer_pin;
  } lhb_out_t;

  // configuration register file contents
  typedef struct packed {
    logic             led_active_high;
    logic [CFG_W-1:0] long_hold;
    logic [CFG_W-1:0] short_hold;
    logic [CFG_W-1:0] short_beep;
    logic [CFG_W-1:0] short_gap;
    logic [CFG_W-1:0] long_beep;
  } lhb_cfg_t;

  // buzzer status towards the top level
  typedef struct packed {
    logic active_q;
    logic active_d;
  } lhb_buzz_sts_t;

  // clamp a 16-bit length to the timer range
  function automatic logic [TIMER_W-1:0] sat_timer(input logic [15:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_W'(v);
  endfunction

endpackage

// ----- design/lhb_cfg_regs.sv -----
// configuration registers of the led hold and beep pattern sequencer
// depends on lhb_pkg

module lhb_cfg_regs
  import lhb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output lhb_cfg_t             cfg_o
);

  lhb_cfg_t cfg_q, cfg_d;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_HIGH: cfg_d.led_active_high = cfg_data_i[0];
        CFG_LONG_HOLD:   cfg_d.long_hold       = cfg_data_i;
        CFG_SHORT_HOLD:  cfg_d.short_hold      = cfg_data_i;
        CFG_SHORT_BEEP:  cfg_d.short_beep      = cfg_data_i;
        CFG_SHORT_GAP:   cfg_d.short_gap       = cfg_data_i;
        CFG_LONG_BEEP:   cfg_d.long_beep       = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_active_high <= 1'b1;
      cfg_q.long_hold       <= RST_LONG_HOLD;
      cfg_q.short_hold      <= RST_SHORT_HOLD;
      cfg_q.short_beep      <= RST_SHORT_BEEP;
      cfg_q.short_gap       <= RST_SHORT_GAP;
      cfg_q.long_beep       <= RST_LONG_BEEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/lhb_led_ctrl.sv -----
// led colour and hold countdown of the sequencer
// depends on lhb_pkg

module lhb_led_ctrl
  import lhb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  lhb_in_t  item_i,
  input  lhb_cfg_t cfg_i,
  output logic [2:0] lit_d_o
);

  logic [2:0]         lit_q, lit_d;
  logic               hold_pend_q, hold_pend_d;
  logic [TIMER_W-1:0] hold_left_q, hold_left_d;
  logic [2:0]         paint;

  // a component above the threshold counts as lit
  assign paint = {item_i.blue_level  > LIT_THRESHOLD,
                  item_i.green_level > LIT_THRESHOLD,
                  item_i.red_level   > LIT_THRESHOLD};

  // next led state for the item in the input stage
  always_comb begin
    lit_d       = lit_q;
    hold_pend_d = hold_pend_q;
    hold_left_d = hold_left_q;
    if (step_i) begin
      case (req_e'(item_i.req_type))
        REQ_TICK: begin
          if (hold_pend_q) begin
            if (hold_left_q <= TIMER_W'(1)) begin
              hold_pend_d = 1'b0;
              hold_left_d = '0;
              lit_d       = LIT_NONE;
            end else begin
              hold_left_d = hold_left_q - TIMER_W'(1);
            end
          end
        end
        REQ_COLOUR: begin
          hold_pend_d = 1'b0;
          lit_d       = paint;
        end
        REQ_LED_OFF: lit_d = LIT_NONE;
        REQ_BEEPS:   lit_d = lit_q;
        REQ_SUCCESS: begin
          lit_d       = LIT_GREEN;
          hold_pend_d = 1'b1;
          hold_left_d = sat_timer(cfg_i.long_hold);
        end
        REQ_ERROR: begin
          lit_d       = LIT_RED;
          hold_pend_d = 1'b1;
          hold_left_d = sat_timer(cfg_i.long_hold);
        end
        REQ_SCAN: begin
          lit_d       = LIT_BLUE;
          hold_pend_d = 1'b1;
          hold_left_d = sat_timer(cfg_i.short_hold);
        end
        REQ_WRITE: begin
          lit_d       = LIT_BLUE;
          hold_pend_d = 1'b1;
          hold_left_d = sat_timer(cfg_i.long_hold);
        end
        default: lit_d = lit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q       <= LIT_NONE;
      hold_pend_q <= 1'b0;
      hold_left_q <= '0;
    end else begin
      lit_q       <= lit_d;
      hold_pend_q <= hold_pend_d;
      hold_left_q <= hold_left_d;
    end
  end

  assign lit_d_o = lit_d;

endmodule

// ----- design/lhb_buzz_ctrl.sv -----
// beep pattern sequencer: beep count, on and gap countdowns
// depends on lhb_pkg

module lhb_buzz_ctrl
  import lhb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  lhb_in_t       item_i,
  input  lhb_cfg_t      cfg_i,
  output lhb_buzz_sts_t sts_o
);

  logic               active_q, active_d;
  logic [COUNT_W-1:0] beeps_q, beeps_d;
  logic [TIMER_W-1:0] on_left_q, on_left_d;
  logic [TIMER_W-1:0] gap_left_q, gap_left_d;
  logic [TIMER_W-1:0] pat_on_q, pat_on_d;
  logic [TIMER_W-1:0] pat_gap_q, pat_gap_d;

  // next buzzer state for the item in the input stage
  always_comb begin
    active_d   = active_q;
    beeps_d    = beeps_q;
    on_left_d  = on_left_q;
    gap_left_d = gap_left_q;
    pat_on_d   = pat_on_q;
    pat_gap_d  = pat_gap_q;
    if (step_i) begin
      case (req_e'(item_i.req_type))
        REQ_TICK: begin
          if (active_q) begin
            // beep running
            if (on_left_q <= TIMER_W'(1)) begin
              active_d  = 1'b0;
              on_left_d = '0;
              if (beeps_q != '0) begin
                gap_left_d = pat_gap_q;
              end
            end else begin
              on_left_d = on_left_q - TIMER_W'(1);
            end
          end else if (beeps_q != '0) begin
            // in a gap
            if (gap_left_q <= TIMER_W'(1)) begin
              gap_left_d = '0;
              beeps_d    = beeps_q - COUNT_W'(1);
              on_left_d  = pat_on_q;
              active_d   = 1'b1;
            end else begin
              gap_left_d = gap_left_q - TIMER_W'(1);
            end
          end
        end
        REQ_BEEPS: begin
          beeps_d    = item_i.beep_count;
          pat_on_d   = sat_timer(item_i.beep_on_ticks);
          pat_gap_d  = sat_timer(item_i.beep_gap_ticks);
          gap_left_d = '0;
        end
        REQ_SUCCESS, REQ_WRITE: begin
          beeps_d    = DOUBLE_BEEPS;
          pat_on_d   = sat_timer(cfg_i.short_beep);
          pat_gap_d  = sat_timer(cfg_i.short_gap);
          gap_left_d = '0;
        end
        REQ_ERROR: begin
          beeps_d    = SINGLE_BEEP;
          pat_on_d   = sat_timer(cfg_i.long_beep);
          pat_gap_d  = '0;
          gap_left_d = '0;
        end
        default: active_d = active_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      beeps_q    <= '0;
      on_left_q  <= '0;
      gap_left_q <= '0;
      pat_on_q   <= '0;
      pat_gap_q  <= '0;
    end else begin
      active_q   <= active_d;
      beeps_q    <= beeps_d;
      on_left_q  <= on_left_d;
      gap_left_q <= gap_left_d;
      pat_on_q   <= pat_on_d;
      pat_gap_q  <= pat_gap_d;
    end
  end

  assign sts_o.active_q = active_q;
  assign sts_o.active_d = active_d;

endmodule

// ----- design/led_hold_and_beep_pattern_sequencer.sv -----
// led hold and beep pattern sequencer, top level
// depends on lhb_pkg, lhb_cfg_regs, lhb_led_ctrl, lhb_buzz_ctrl and the macros header
//
// usage:
//   input channel (in_valid_i / in_ready_o / in_data_i) carries one beat per
//   tick or command; output channel (out_valid_o / out_ready_i / out_data_o)
//   returns one beat of pin levels for every input beat, in order.
//   configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i),
//   written while no beat is in flight; indexes above five are dropped.
// path: a beat accepted is registered in the input stage; once the result
//   register is free, the led and buzzer state is updated from it and its
//   result is loaded into the output register.
// throughput: one beat per cycle while the output is not stalled; the state
//   update is one led/buzzer next-state pass between input and result stage.
// reset: led unlit, no hold, buzzer silent, no pattern, registers at their
//   defaults (active-high legs, holds 1500/250, beeps 60/80/400 ticks).
// stall: a waiting result stays in the output register; the input stage
//   keeps accepting until it is full too, then in_ready_o drops.

`include "led_hold_and_beep_pattern_sequencer_macros.svh"

module led_hold_and_beep_pattern_sequencer
  import lhb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lhb_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lhb_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  lhb_cfg_t      cfg;
  lhb_buzz_sts_t buzz_sts;
  logic [2:0]    lit_d;

  logic     in_vld_q, in_vld_d;
  lhb_in_t  in_q;
  logic     out_vld_q, out_vld_d;
  lhb_out_t out_q, out_d;
  logic     res_load;
  logic     step;

  // handshake: the result register frees when empty or being taken
  assign res_load   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && res_load;
  assign in_ready_o = !in_vld_q || res_load;

  // input stage
  assign in_vld_d = (in_valid_i && in_ready_o) || (in_vld_q && !res_load);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  lhb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lhb_led_ctrl u_led (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .cfg_i   (cfg),
    .lit_d_o (lit_d)
  );

  lhb_buzz_ctrl u_buzz (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .sts_o  (buzz_sts)
  );

  // pin levels after polarity
  always_comb begin
    out_d.red_pin    = lit_d[0] ^ ~cfg.led_active_high;
    out_d.green_pin  = lit_d[1] ^ ~cfg.led_active_high;
    out_d.blue_pin   = lit_d[2] ^ ~cfg.led_active_high;
    out_d.buzzer_pin = buzz_sts.active_d;
  end

  // result stage
  assign out_vld_d = step || (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // checks
  `LHB_ASSERT_NXT(a_in_stage_holds, in_vld_q && !res_load, in_vld_q && $stable(in_q))
  `LHB_ASSERT_NXT(a_step_gives_result, step, out_vld_q)
  `LHB_ASSERT_IMP(a_buzz_moves_on_tick, step && (in_q.req_type != REQ_TICK),
                  buzz_sts.active_d == buzz_sts.active_q)

endmodule

// ----- tb/sv/tb_led_hold_and_beep_pattern_sequencer.sv -----
// self-checking testbench for the led hold and beep pattern sequencer
// drives beats through valid/ready with random idling, predicts pin levels per beat
// depends on lhb_pkg and led_hold_and_beep_pattern_sequencer
`timescale 1ns / 100ps

module tb_led_hold_and_beep_pattern_sequencer
  import lhb_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned PRINT_CAP   = 50;

  // register indexes that the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // one row of the directed table; fixed_on marks a hand-written result
  typedef struct packed {
    lhb_in_t  beat;
    logic     fixed_on;
    lhb_out_t fixed;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  lhb_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  lhb_out_t             out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  // hand-written result travelling with the beat on the input channel
  logic     beat_fixed_on;
  lhb_out_t beat_fixed;
  logic     calm;

  lhb_out_t    pins_due [$];
  int unsigned mismatches;
  int unsigned cycle_count;

  // register copy
  logic             cfg_high       = 1'b1;
  logic [CFG_W-1:0] cfg_long_hold  = RST_LONG_HOLD;
  logic [CFG_W-1:0] cfg_short_hold = RST_SHORT_HOLD;
  logic [CFG_W-1:0] cfg_short_beep = RST_SHORT_BEEP;
  logic [CFG_W-1:0] cfg_short_gap  = RST_SHORT_GAP;
  logic [CFG_W-1:0] cfg_long_beep  = RST_LONG_BEEP;

  // led and buzzer state copy
  logic [2:0]         lit        = LIT_NONE;
  logic               hold_on    = 1'b0;
  logic [TIMER_W-1:0] hold_cnt   = '0;
  logic [COUNT_W-1:0] beeps_left = '0;
  logic               buzzing    = 1'b0;
  logic [TIMER_W-1:0] on_cnt     = '0;
  logic [TIMER_W-1:0] gap_cnt    = '0;
  logic [TIMER_W-1:0] pat_on     = '0;
  logic [TIMER_W-1:0] pat_gap    = '0;

  led_hold_and_beep_pattern_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // lengths are 16 bits wide like the timers, so loading never clips
  function automatic void arm_pattern(logic [COUNT_W-1:0] count, logic [15:0] on_len,
                                      logic [15:0] gap_len);
    beeps_left = count;
    pat_on     = on_len;
    pat_gap    = gap_len;
    gap_cnt    = '0;
  endfunction

  function automatic void arm_cue(logic [2:0] colour, logic [15:0] hold);
    lit      = colour;
    hold_on  = 1'b1;
    hold_cnt = hold;
  endfunction

  // advance the state copy by one beat and return the pins it leaves
  function automatic lhb_out_t next_pin_levels(lhb_in_t b);
    lhb_out_t pins;
    case (req_e'(b.req_type))
      REQ_TICK: begin
        if (hold_on) begin
          if (hold_cnt <= 1) begin
            hold_on  = 1'b0;
            hold_cnt = '0;
            lit      = LIT_NONE;
          end else begin
            hold_cnt = hold_cnt - TIMER_W'(1);
          end
        end
        if (buzzing) begin
          if (on_cnt <= 1) begin
            buzzing = 1'b0;
            on_cnt  = '0;
            if (beeps_left != 0) gap_cnt = pat_gap;
          end else begin
            on_cnt = on_cnt - TIMER_W'(1);
          end
        end else if (beeps_left != 0) begin
          if (gap_cnt <= 1) begin
            gap_cnt    = '0;
            beeps_left = beeps_left - COUNT_W'(1);
            on_cnt     = pat_on;
            buzzing    = 1'b1;
          end else begin
            gap_cnt = gap_cnt - TIMER_W'(1);
          end
        end
      end
      REQ_COLOUR: begin
        hold_on = 1'b0;
        lit = {b.blue_level > LIT_THRESHOLD, b.green_level > LIT_THRESHOLD,
               b.red_level > LIT_THRESHOLD};
      end
      REQ_LED_OFF: lit = LIT_NONE;
      REQ_BEEPS: arm_pattern(b.beep_count, b.beep_on_ticks, b.beep_gap_ticks);
      REQ_SUCCESS: begin
        arm_cue(LIT_GREEN, cfg_long_hold);
        arm_pattern(DOUBLE_BEEPS, cfg_short_beep, cfg_short_gap);
      end
      REQ_ERROR: begin
        arm_cue(LIT_RED, cfg_long_hold);
        arm_pattern(SINGLE_BEEP, cfg_long_beep, '0);
      end
      REQ_SCAN: arm_cue(LIT_BLUE, cfg_short_hold);
      REQ_WRITE: begin
        arm_cue(LIT_BLUE, cfg_long_hold);
        arm_pattern(DOUBLE_BEEPS, cfg_short_beep, cfg_short_gap);
      end
      default: ;
    endcase
    pins.red_pin    = lit[0] ^ ~cfg_high;
    pins.green_pin  = lit[1] ^ ~cfg_high;
    pins.blue_pin   = lit[2] ^ ~cfg_high;
    pins.buzzer_pin = buzzing;
    return pins;
  endfunction

  function automatic stim_row_t stim_row(req_e req, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] bl, logic [7:0] cnt, logic [15:0] on_len,
                                         logic [15:0] gap_len, logic fixed_on,
                                         logic [3:0] fixed);
    stim_row_t row;
    row.beat.req_type       = req;
    row.beat.red_level      = r;
    row.beat.green_level    = g;
    row.beat.blue_level     = bl;
    row.beat.beep_count     = cnt;
    row.beat.beep_on_ticks  = on_len;
    row.beat.beep_gap_ticks = gap_len;
    row.fixed_on            = fixed_on;
    row.fixed               = lhb_out_t'(fixed);
    return row;
  endfunction

  // mostly ticks; unused fields stay random so every bit moves
  function automatic lhb_in_t random_beat();
    lhb_in_t     b;
    int unsigned pick;
    b.red_level      = 8'($urandom);
    b.green_level    = 8'($urandom);
    b.blue_level     = 8'($urandom);
    b.beep_count     = 8'($urandom);
    b.beep_on_ticks  = 16'($urandom);
    b.beep_gap_ticks = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 55)      b.req_type = REQ_TICK;
    else if (pick < 63) b.req_type = REQ_COLOUR;
    else if (pick < 68) b.req_type = REQ_LED_OFF;
    else if (pick < 78) b.req_type = REQ_BEEPS;
    else if (pick < 84) b.req_type = REQ_SUCCESS;
    else if (pick < 89) b.req_type = REQ_ERROR;
    else if (pick < 94) b.req_type = REQ_SCAN;
    else                b.req_type = REQ_WRITE;
    // keep patterns short enough to play out within a phase
    if (b.req_type == REQ_BEEPS) begin
      b.beep_count     = 8'($urandom_range(4));
      b.beep_on_ticks  = 16'($urandom_range(6));
      b.beep_gap_ticks = 16'($urandom_range(6));
    end
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // offer one beat, idling first at random, and wait for it to be taken
  task automatic send_beat(input lhb_in_t b, input logic fixed_on, input lhb_out_t fixed);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_data_i     <= b;
    beat_fixed_on <= fixed_on;
    beat_fixed    <= fixed;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // result side stalls at random except in the calm phase
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= calm || ($urandom_range(99) >= 35);
    end
  end

  // check each result beat against the oldest expectation, then log new input beats
  always @(posedge clk_i) begin : pin_check
    lhb_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pins_due.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing expected", out_data_o));
      end else begin
        want = pins_due.pop_front();
        if (out_data_o.red_pin !== want.red_pin)
          report_mismatch($sformatf("red pin %b, want %b", out_data_o.red_pin, want.red_pin));
        if (out_data_o.green_pin !== want.green_pin)
          report_mismatch($sformatf("green pin %b, want %b", out_data_o.green_pin,
                                    want.green_pin));
        if (out_data_o.blue_pin !== want.blue_pin)
          report_mismatch($sformatf("blue pin %b, want %b", out_data_o.blue_pin,
                                    want.blue_pin));
        if (out_data_o.buzzer_pin !== want.buzzer_pin)
          report_mismatch($sformatf("buzzer pin %b, want %b", out_data_o.buzzer_pin,
                                    want.buzzer_pin));
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      want = next_pin_levels(in_data_i);
      pins_due.push_back(beat_fixed_on ? beat_fixed : want);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t            dir_rows [$];
    logic [CFG_W-1:0]     reg_vals [0:2**CFG_IDX_W-1];
    logic [CFG_IDX_W-1:0] idx;
    int unsigned          phase;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ACTIVE_HIGH;
    cfg_data_i    = '0;
    beat_fixed_on = 1'b0;
    beat_fixed    = '0;
    calm          = 1'b0;
    mismatches    = 0;
    cycle_count   = 0;

    // directed table at reset settings; pins are {red, green, blue, buzzer}
    dir_rows.push_back(stim_row(REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b0000));
    dir_rows.push_back(stim_row(REQ_COLOUR,  8'hff, 8'hff, 8'hff, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b1110));
    dir_rows.push_back(stim_row(REQ_COLOUR,  8'h80, 8'h7f, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b1000));
    dir_rows.push_back(stim_row(REQ_COLOUR,  8'h7f, 8'h80, 8'h80, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b0110));
    dir_rows.push_back(stim_row(REQ_LED_OFF, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff,
                                16'hffff, 1'b1, 4'b0000));
    dir_rows.push_back(stim_row(REQ_ERROR,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b1000));
    dir_rows.push_back(stim_row(REQ_SUCCESS, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b0100));
    // first beat starts on the next tick
    dir_rows.push_back(stim_row(REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b0101));
    // led off keeps the hold armed
    dir_rows.push_back(stim_row(REQ_LED_OFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b0001));
    dir_rows.push_back(stim_row(REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b0, 4'b0000));
    dir_rows.push_back(stim_row(REQ_SCAN,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b1, 4'b0011));
    dir_rows.push_back(stim_row(REQ_WRITE,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b0, 4'b0000));
    // set colour drops the pending hold
    dir_rows.push_back(stim_row(REQ_COLOUR,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b0, 4'b0000));
    // zero beat count
    dir_rows.push_back(stim_row(REQ_BEEPS,   8'h00, 8'h00, 8'h00, 8'h00, 16'h0005,
                                16'h0005, 1'b0, 4'b0000));
    dir_rows.push_back(stim_row(REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                16'h0000, 1'b0, 4'b0000));
    // new pattern while sounding, zero lengths act as one tick
    dir_rows.push_back(stim_row(REQ_BEEPS,   8'h00, 8'h00, 8'h00, 8'h03, 16'h0000,
                                16'h0000, 1'b0, 4'b0000));
    repeat (3)
      dir_rows.push_back(stim_row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                  16'h0000, 1'b0, 4'b0000));
    // widest pattern, replaced before any tick plays it
    dir_rows.push_back(stim_row(REQ_BEEPS,   8'h00, 8'h00, 8'h00, 8'hff, 16'hffff,
                                16'hffff, 1'b0, 4'b0000));
    dir_rows.push_back(stim_row(REQ_BEEPS,   8'h00, 8'h00, 8'h00, 8'h01, 16'h0001,
                                16'h0000, 1'b0, 4'b0000));
    repeat (2)
      dir_rows.push_back(stim_row(REQ_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
                                  16'h0000, 1'b0, 4'b0000));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].fixed_on, dir_rows[i].fixed);
    drain();

    // random phases, each under its own register settings
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        // active-low legs, zero and minimum lengths; only bit 0 of the polarity counts
        0: begin
          reg_vals[CFG_ACTIVE_HIGH] = 16'hfffe;
          reg_vals[CFG_LONG_HOLD]   = 16'h0000;
          reg_vals[CFG_SHORT_HOLD]  = 16'h0001;
          reg_vals[CFG_SHORT_BEEP]  = 16'h0000;
          reg_vals[CFG_SHORT_GAP]   = 16'h0000;
          reg_vals[CFG_LONG_BEEP]   = 16'h0001;
          reg_vals[CFG_SPARE_LO]    = 16'hffff;
          reg_vals[CFG_SPARE_HI]    = 16'hffff;
        end
        // longest lengths last, so a stuck buzzer costs nothing later
        PHASES - 1: begin
          reg_vals[CFG_ACTIVE_HIGH] = 16'h0001;
          reg_vals[CFG_LONG_HOLD]   = 16'hffff;
          reg_vals[CFG_SHORT_HOLD]  = 16'hffff;
          reg_vals[CFG_SHORT_BEEP]  = 16'hffff;
          reg_vals[CFG_SHORT_GAP]   = 16'hffff;
          reg_vals[CFG_LONG_BEEP]   = 16'hffff;
          reg_vals[CFG_SPARE_LO]    = 16'h0000;
          reg_vals[CFG_SPARE_HI]    = 16'h0000;
        end
        default: begin
          reg_vals[CFG_ACTIVE_HIGH] = 16'($urandom);
          reg_vals[CFG_LONG_HOLD]   = 16'($urandom_range(12));
          reg_vals[CFG_SHORT_HOLD]  = 16'($urandom_range(12));
          reg_vals[CFG_SHORT_BEEP]  = 16'($urandom_range(6));
          reg_vals[CFG_SHORT_GAP]   = 16'($urandom_range(6));
          reg_vals[CFG_LONG_BEEP]   = 16'($urandom_range(6));
          reg_vals[CFG_SPARE_LO]    = 16'($urandom);
          reg_vals[CFG_SPARE_HI]    = 16'($urandom);
        end
      endcase

      // write every index, spares included, and mirror the ones that exist
      for (int i = 0; i < 2**CFG_IDX_W; i++) begin
        idx = CFG_IDX_W'(i);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= idx;
        cfg_data_i <= reg_vals[i];
        @(posedge clk_i);
        case (idx)
          CFG_ACTIVE_HIGH: cfg_high       = reg_vals[i][0];
          CFG_LONG_HOLD:   cfg_long_hold  = reg_vals[i];
          CFG_SHORT_HOLD:  cfg_short_hold = reg_vals[i];
          CFG_SHORT_BEEP:  cfg_short_beep = reg_vals[i];
          CFG_SHORT_GAP:   cfg_short_gap  = reg_vals[i];
          CFG_LONG_BEEP:   cfg_long_beep  = reg_vals[i];
          default: ;
        endcase
      end
      cfg_we_i <= 1'b0;
      calm     <= (phase == 2);
      @(posedge clk_i);

      repeat (phase == PHASES - 1 ? 50 : 100) send_beat(random_beat(), 1'b0, '0);
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
